### rtl/core/tpvc_pkg.sv
package tpvc_pkg;

  localparam int TempW    = 16;
  localparam int DeadW    = 12;
  localparam int TimeW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 24;
  localparam int InUserW  = 3;
  localparam int OutDataW = 8;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_MAIN   = 2'd1,
    ACT_SUPPLY = 2'd2,
    ACT_UPDATE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_OPEN  = 2'd1,
    DIR_CLOSE = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_OPENING = 2'd1,
    ST_CLOSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLED      = 3'd0,
    REG_SETPOINT     = 3'd1,
    REG_SUMMER_MODE  = 3'd2,
    REG_DEAD_ZONE    = 3'd3,
    REG_LIMIT_MODE   = 3'd4,
    REG_SUPPLY_HIGH  = 3'd5,
    REG_SUPPLY_LOW   = 3'd6,
    REG_MOVE_TIMEOUT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                    enabled;
    logic signed [TempW-1:0] setpoint;
    logic                    summer_mode;
    logic [DeadW-1:0]        dead_zone;
    logic                    limit_mode;
    logic signed [TempW-1:0] supply_high;
    logic signed [TempW-1:0] supply_low;
    logic [TimeW-1:0]        move_timeout;
  } cfg_t;

  typedef struct packed {
    logic       open_drive;
    logic       close_drive;
    logic [1:0] valve_status;
    logic       full_open;
    logic       full_closed;
  } result_t;

  typedef struct packed {
    logic                    valid;
    logic [1:0]              action;
    logic signed [TempW-1:0] temperature;
    logic                    sensor_fault;
    logic                    controller_on;
  } item_t;

endpackage

### rtl/core/tpvc_cfg.sv
module tpvc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tpvc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tpvc_pkg::CfgDataW-1:0]     cfg_wdata,
  output tpvc_pkg::cfg_t                    cfg
);

  tpvc_pkg::cfg_t cfg_r;
  tpvc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (tpvc_pkg::reg_idx_t'(cfg_index))
        tpvc_pkg::REG_ENABLED:      cfg_nxt.enabled      = cfg_wdata[0];
        tpvc_pkg::REG_SETPOINT:     cfg_nxt.setpoint     = cfg_wdata;
        tpvc_pkg::REG_SUMMER_MODE:  cfg_nxt.summer_mode  = cfg_wdata[0];
        tpvc_pkg::REG_DEAD_ZONE:    cfg_nxt.dead_zone    = cfg_wdata[tpvc_pkg::DeadW-1:0];
        tpvc_pkg::REG_LIMIT_MODE:   cfg_nxt.limit_mode   = cfg_wdata[0];
        tpvc_pkg::REG_SUPPLY_HIGH:  cfg_nxt.supply_high  = cfg_wdata;
        tpvc_pkg::REG_SUPPLY_LOW:   cfg_nxt.supply_low   = cfg_wdata;
        tpvc_pkg::REG_MOVE_TIMEOUT: cfg_nxt.move_timeout = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled      <= 1'b1;
      cfg_r.setpoint     <= 16'sd320;
      cfg_r.summer_mode  <= 1'b1;
      cfg_r.dead_zone    <= 12'd16;
      cfg_r.limit_mode   <= 1'b0;
      cfg_r.supply_high  <= 16'sd560;
      cfg_r.supply_low   <= 16'sd256;
      cfg_r.move_timeout <= 16'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/tpvc_core.sv
module tpvc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  tpvc_pkg::cfg_t      cfg,
  input  tpvc_pkg::item_t     item,
  output tpvc_pkg::result_t   res_nxt
);

  logic signed [tpvc_pkg::TempW-1:0] main_temp_r, main_temp_nxt;
  logic                              main_fresh_r, main_fresh_nxt;
  logic                              main_fault_r, main_fault_nxt;
  logic signed [tpvc_pkg::TempW-1:0] supply_temp_r, supply_temp_nxt;
  logic                              supply_fresh_r, supply_fresh_nxt;
  logic                              supply_fault_r, supply_fault_nxt;
  tpvc_pkg::dir_t                    dir_r, dir_nxt;
  logic [tpvc_pkg::TimeW-1:0]        elapsed_r, elapsed_nxt;
  logic                              open_r, open_nxt;
  logic                              close_r, close_nxt;
  tpvc_pkg::status_t                 status_r, status_nxt;
  logic                              open_end_r, open_end_nxt;
  logic                              closed_end_r, closed_end_nxt;

  logic signed [tpvc_pkg::TempW:0]   diff;
  logic signed [tpvc_pkg::TempW+1:0] err2;
  logic signed [tpvc_pkg::TempW+1:0] dz;
  logic signed [tpvc_pkg::TempW+1:0] ndz;
  tpvc_pkg::cmd_t                    reg_cmd;
  tpvc_pkg::cmd_t                    cmd;
  logic                              timed_out;

  always_comb begin
    if (cfg.summer_mode) begin
      diff = {main_temp_r[tpvc_pkg::TempW-1], main_temp_r}
           - {cfg.setpoint[tpvc_pkg::TempW-1], cfg.setpoint};
    end else begin
      diff = {cfg.setpoint[tpvc_pkg::TempW-1], cfg.setpoint}
           - {main_temp_r[tpvc_pkg::TempW-1], main_temp_r};
    end
    err2 = {diff, 1'b0};
    dz   = signed'({{(tpvc_pkg::TempW+2-tpvc_pkg::DeadW){1'b0}}, cfg.dead_zone});
    ndz  = -dz;
    if (err2 > dz) begin
      reg_cmd = tpvc_pkg::CMD_OPEN;
    end else if (err2 < ndz) begin
      reg_cmd = tpvc_pkg::CMD_CLOSE;
    end else begin
      reg_cmd = tpvc_pkg::CMD_STOP;
    end
  end

  assign timed_out = elapsed_r > cfg.move_timeout;

  always_comb begin
    main_temp_nxt    = main_temp_r;
    main_fresh_nxt   = main_fresh_r;
    main_fault_nxt   = main_fault_r;
    supply_temp_nxt  = supply_temp_r;
    supply_fresh_nxt = supply_fresh_r;
    supply_fault_nxt = supply_fault_r;
    dir_nxt          = dir_r;
    elapsed_nxt      = elapsed_r;
    open_nxt         = open_r;
    close_nxt        = close_r;
    status_nxt       = status_r;
    open_end_nxt     = open_end_r;
    closed_end_nxt   = closed_end_r;
    cmd              = tpvc_pkg::CMD_NONE;

    if (item.valid) begin
      case (tpvc_pkg::action_t'(item.action))
        tpvc_pkg::ACT_TICK: begin
          if (dir_r != tpvc_pkg::DIR_NONE && elapsed_r != '1) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
        end
        tpvc_pkg::ACT_MAIN: begin
          main_temp_nxt  = item.temperature;
          main_fault_nxt = item.sensor_fault;
          main_fresh_nxt = 1'b1;
        end
        tpvc_pkg::ACT_SUPPLY: begin
          if (cfg.limit_mode) begin
            supply_temp_nxt  = item.temperature;
            supply_fault_nxt = item.sensor_fault;
            supply_fresh_nxt = 1'b1;
          end
        end
        tpvc_pkg::ACT_UPDATE: begin
          if (cfg.enabled) begin
            if (!item.controller_on) begin
              cmd = tpvc_pkg::CMD_CLOSE;
            end else if (cfg.limit_mode) begin
              if (main_fault_r || supply_fault_r) begin
                cmd = tpvc_pkg::CMD_STOP;
              end else if (main_fresh_r && supply_fresh_r) begin
                main_fresh_nxt   = 1'b0;
                supply_fresh_nxt = 1'b0;
                if (supply_temp_r > cfg.supply_high || supply_temp_r < cfg.supply_low) begin
                  cmd = tpvc_pkg::CMD_CLOSE;
                end else begin
                  cmd = reg_cmd;
                end
              end
            end else begin
              if (main_fault_r) begin
                cmd = tpvc_pkg::CMD_CLOSE;
              end else if (main_fresh_r) begin
                main_fresh_nxt = 1'b0;
                cmd = reg_cmd;
              end
            end
          end
        end
        default: ;
      endcase
    end

    case (cmd)
      tpvc_pkg::CMD_OPEN: begin
        if (dir_r != tpvc_pkg::DIR_OPEN) begin
          close_nxt      = 1'b0;
          open_nxt       = 1'b1;
          dir_nxt        = tpvc_pkg::DIR_OPEN;
          elapsed_nxt    = '0;
          closed_end_nxt = 1'b0;
          status_nxt     = tpvc_pkg::ST_OPENING;
        end else if (timed_out) begin
          open_nxt       = 1'b0;
          open_end_nxt   = 1'b1;
          closed_end_nxt = 1'b0;
          status_nxt     = tpvc_pkg::ST_STOPPED;
        end else begin
          open_end_nxt   = 1'b0;
          closed_end_nxt = 1'b0;
        end
      end
      tpvc_pkg::CMD_CLOSE: begin
        if (dir_r != tpvc_pkg::DIR_CLOSE) begin
          open_nxt     = 1'b0;
          close_nxt    = 1'b1;
          dir_nxt      = tpvc_pkg::DIR_CLOSE;
          elapsed_nxt  = '0;
          open_end_nxt = 1'b0;
          status_nxt   = tpvc_pkg::ST_CLOSING;
        end else if (timed_out) begin
          close_nxt      = 1'b0;
          closed_end_nxt = 1'b1;
          status_nxt     = tpvc_pkg::ST_STOPPED;
        end else begin
          open_end_nxt   = 1'b0;
          closed_end_nxt = 1'b0;
        end
      end
      tpvc_pkg::CMD_STOP: begin
        open_nxt    = 1'b0;
        close_nxt   = 1'b0;
        dir_nxt     = tpvc_pkg::DIR_NONE;
        elapsed_nxt = '0;
        status_nxt  = tpvc_pkg::ST_STOPPED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_temp_r    <= '0;
      main_fresh_r   <= 1'b0;
      main_fault_r   <= 1'b0;
      supply_temp_r  <= '0;
      supply_fresh_r <= 1'b0;
      supply_fault_r <= 1'b0;
      dir_r          <= tpvc_pkg::DIR_NONE;
      elapsed_r      <= '0;
      open_r         <= 1'b0;
      close_r        <= 1'b0;
      status_r       <= tpvc_pkg::ST_STOPPED;
      open_end_r     <= 1'b0;
      closed_end_r   <= 1'b0;
    end else begin
      main_temp_r    <= main_temp_nxt;
      main_fresh_r   <= main_fresh_nxt;
      main_fault_r   <= main_fault_nxt;
      supply_temp_r  <= supply_temp_nxt;
      supply_fresh_r <= supply_fresh_nxt;
      supply_fault_r <= supply_fault_nxt;
      dir_r          <= dir_nxt;
      elapsed_r      <= elapsed_nxt;
      open_r         <= open_nxt;
      close_r        <= close_nxt;
      status_r       <= status_nxt;
      open_end_r     <= open_end_nxt;
      closed_end_r   <= closed_end_nxt;
    end
  end

  assign res_nxt.open_drive   = open_nxt;
  assign res_nxt.close_drive  = close_nxt;
  assign res_nxt.valve_status = status_nxt;
  assign res_nxt.full_open    = open_end_nxt;
  assign res_nxt.full_closed  = closed_end_nxt;

`ifndef ASSERT_OFF
  a_relays_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(open_r && close_r))
    else $error("open and close relays driven together");

  a_status_matches_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == tpvc_pkg::ST_OPENING) == open_r &&
    (status_r == tpvc_pkg::ST_CLOSING) == close_r)
    else $error("valve status disagrees with relay state");

  a_idle_no_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    dir_r == tpvc_pkg::DIR_NONE |-> elapsed_r == '0)
    else $error("move time counted without a move");

  a_tick_only_counts: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r != '0 && $past(rst_n) && $past(elapsed_r) != elapsed_r
      |-> elapsed_r == $past(elapsed_r) + 1'b1)
    else $error("move time changed other than by one step");
`endif

endmodule

### rtl/core/three_point_valve_controller.sv
// The result of an accepted item shows in the output register
// at the next clock edge.
// Throughput: one item per cycle while out_tready is high; in_tready follows the
// output register, which refills in the cycle its result is taken.
// Reset: synchronous active-low rst_n clears all control state, loads the default
// register values and empties the output register.
module three_point_valve_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] temperature, [16] controller_on, [23:17] zero
  input  logic [tpvc_pkg::InDataW-1:0]       in_tdata,
  // [1:0] action, [2] sensor_fault
  input  logic [tpvc_pkg::InUserW-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] open_drive, [1] close_drive, [3:2] valve_status, [4] full_open,
  // [5] full_closed, [7:6] zero
  output logic [tpvc_pkg::OutDataW-1:0]      out_tdata,
  input  logic                               cfg_we,
  input  logic [tpvc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [tpvc_pkg::CfgDataW-1:0]      cfg_wdata
);

  tpvc_pkg::cfg_t    cfg;
  tpvc_pkg::item_t   item;
  tpvc_pkg::result_t res_nxt;
  tpvc_pkg::result_t res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign item.valid         = in_fire;
  assign item.action        = in_tuser[1:0];
  assign item.sensor_fault  = in_tuser[2];
  assign item.temperature   = in_tdata[tpvc_pkg::TempW-1:0];
  assign item.controller_on = in_tdata[tpvc_pkg::TempW];

  tpvc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpvc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (item),
    .res_nxt (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.full_closed, res_r.full_open, res_r.valve_status,
                       res_r.close_drive, res_r.open_drive};

endmodule
